### rtl/bwms_pkg.sv
// ----------------------------------------------------------------------------
// bwms_pkg
// Shared widths, reset values and register codes of the wrap-around bilinear
// map sampler.
// ----------------------------------------------------------------------------
package bwms_pkg;

  // field widths
  localparam int MAP_W      = 11;
  localparam int SRC_W      = 27;
  localparam int IDX_W      = 20;
  localparam int COMP_W     = 32;
  localparam int QRY_W      = 28;
  localparam int ENTRY_W    = 2 * COMP_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // parameter defaults
  localparam int MAX_DIM_DEF   = 1024;
  localparam int FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [MAP_W-1:0] MAP_W_RST = MAP_W'(528);
  localparam logic [MAP_W-1:0] MAP_H_RST = MAP_W'(528);
  localparam logic [SRC_W-1:0] SRC_W_RST = SRC_W'(135168);
  localparam logic [SRC_W-1:0] SRC_H_RST = SRC_W'(135168);

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_MAP_WIDTH     = 2'd0,
    REG_MAP_HEIGHT    = 2'd1,
    REG_SOURCE_WIDTH  = 2'd2,
    REG_SOURCE_HEIGHT = 2'd3
  } reg_idx_t;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

### rtl/bwms_if.sv
// ----------------------------------------------------------------------------
// bwms_in_if / bwms_out_if
// Valid/ready channels of the sampler: request items in, sample items out.
// ----------------------------------------------------------------------------
interface bwms_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [bwms_pkg::IDX_W-1:0]          entry_index;
  logic signed [bwms_pkg::COMP_W-1:0]  entry_u;
  logic signed [bwms_pkg::COMP_W-1:0]  entry_v;
  logic signed [bwms_pkg::QRY_W-1:0]   query_x;
  logic signed [bwms_pkg::QRY_W-1:0]   query_y;

  modport source (output valid, req_type, entry_index, entry_u, entry_v, query_x, query_y,
                  input ready);
  modport sink   (input valid, req_type, entry_index, entry_u, entry_v, query_x, query_y,
                  output ready);
endinterface

interface bwms_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bwms_pkg::COMP_W-1:0]  sample_u;
  logic signed [bwms_pkg::COMP_W-1:0]  sample_v;

  modport source (output valid, sample_u, sample_v, input ready);
  modport sink   (input valid, sample_u, sample_v, output ready);
endinterface

### rtl/bwms_div.sv
// ----------------------------------------------------------------------------
// bwms_div
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient and
// remainder once all NUM_W quotient bits are in, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module bwms_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // trial subtraction of this step
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], qbit};
      rem_r <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

### rtl/bilinear_wrap_map_sampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_wrap_map_sampler_core
// Table of (u, v) entries with wrap-around bilinear sampling of query points.
// ----------------------------------------------------------------------------
// A write item stores one 64-bit entry in a table of 2^20 entries with one
// write port and one read port. A query item runs two bit-serial divider
// passes, one scaling each axis by map size over source size, one wrapping
// the cell modulo map size minus one, then four reads of the one read port
// and three blend steps; the last step waits while the previous sample still
// blocks the output register. A new item is taken the cycle after the sample
// is loaded, even while it still waits in the output register. Table entries
// are undefined until written.
module bilinear_wrap_map_sampler_core #(
  parameter int MAX_DIM   = bwms_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = bwms_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bwms_in_if.sink                       in_ch,
  bwms_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bwms_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bwms_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bwms_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import bwms_pkg::*;

  localparam int SZW   = $clog2(MAX_DIM + 1);
  localparam int NUM_W = SZW + (QRY_W - 1) + FRAC_BITS - 8;
  localparam int POS_W = NUM_W + 1;
  localparam int CELL_W = POS_W - FRAC_BITS;
  localparam int ROW_W = 2 * SZW;
  localparam int ADD_W = ROW_W + 1;
  localparam int ACC_W = FRAC_BITS + COMP_W + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL  = 11'b00000000010,
    S_DIV  = 11'b00000000100,
    S_CELL = 11'b00000001000,
    S_MOD  = 11'b00000010000,
    S_WRAP = 11'b00000100000,
    S_ADDR = 11'b00001000000,
    S_READ = 11'b00010000000,
    S_BT   = 11'b00100000000,
    S_BB   = 11'b01000000000,
    S_BY   = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] u;
    logic signed [COMP_W-1:0] v;
  } entry_t;

  // one blend step: floor((S-f)*a + f*b + S/2) / S
  function automatic logic signed [COMP_W-1:0] blend(
    input logic signed [COMP_W-1:0] a,
    input logic signed [COMP_W-1:0] b,
    input logic [FRAC_BITS-1:0]     f
  );
    logic signed [COMP_W:0]  d;
    logic signed [ACC_W-1:0] acc;
    d   = $signed({b[COMP_W-1], b}) - $signed({a[COMP_W-1], a});
    acc = (ACC_W'(a) <<< FRAC_BITS) + ACC_W'($signed({1'b0, f}) * d) + HALF;
    return acc[FRAC_BITS+COMP_W-1:FRAC_BITS];
  endfunction

  // configuration registers
  logic [MAP_W-1:0] map_w_r, map_h_r;
  logic [SRC_W-1:0] src_w_r, src_h_r;
  logic             cfg_wr;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= MAP_W_RST;
      map_h_r <= MAP_H_RST;
      src_w_r <= SRC_W_RST;
      src_h_r <= SRC_H_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_MAP_WIDTH:     map_w_r <= cfg_pwdata[MAP_W-1:0];
        REG_MAP_HEIGHT:    map_h_r <= cfg_pwdata[MAP_W-1:0];
        REG_SOURCE_WIDTH:  src_w_r <= cfg_pwdata[SRC_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r <= cfg_pwdata[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_MAP_WIDTH:     cfg_prdata = CFG_DATA_W'(map_w_r);
      REG_MAP_HEIGHT:    cfg_prdata = CFG_DATA_W'(map_h_r);
      REG_SOURCE_WIDTH:  cfg_prdata = CFG_DATA_W'(src_w_r);
      REG_SOURCE_HEIGHT: cfg_prdata = CFG_DATA_W'(src_h_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // effective sizes: map clamped to 2..MAX_DIM, source at least 1
  logic [SZW-1:0]   size_x, size_y;
  logic [SRC_W-1:0] den_x, den_y;

  always_comb begin
    if (map_w_r < MAP_W'(2))            size_x = SZW'(2);
    else if (32'(map_w_r) > MAX_DIM)    size_x = SZW'(MAX_DIM);
    else                                size_x = SZW'(map_w_r);
    if (map_h_r < MAP_W'(2))            size_y = SZW'(2);
    else if (32'(map_h_r) > MAX_DIM)    size_y = SZW'(MAX_DIM);
    else                                size_y = SZW'(map_h_r);
    den_x = (src_w_r == '0) ? SRC_W'(1) : src_w_r;
    den_y = (src_h_r == '0) ? SRC_W'(1) : src_h_r;
  end

  // sequencer and datapath registers
  state_t                     state_r;
  logic signed [QRY_W-1:0]    qx_r, qy_r;
  logic signed [POS_W-1:0]    posx_r, posy_r;
  logic [SZW-1:0]             x0_r, x1_r, y0_r, y1_r;
  logic [ROW_W-1:0]           rb0_r, rb1_r;
  logic [2:0]                 rd_cnt_r;
  entry_t                     ent_r [4];
  entry_t                     top_r, bot_r;
  logic                       out_valid_r;
  logic signed [COMP_W-1:0]   out_u_r, out_v_r;

  logic in_acc, out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // scaled numerators: |q| * size * 2^(FRAC_BITS-8)
  logic [QRY_W-1:0]        qx_abs, qy_abs;
  logic [SZW+QRY_W-1:0]    px, py;
  logic [NUM_W-1:0]        magx, magy;

  always_comb begin
    qx_abs = qx_r[QRY_W-1] ? QRY_W'(-qx_r) : QRY_W'(qx_r);
    qy_abs = qy_r[QRY_W-1] ? QRY_W'(-qy_r) : QRY_W'(qy_r);
    px     = (SZW+QRY_W)'(size_x) * (SZW+QRY_W)'(qx_abs);
    py     = (SZW+QRY_W)'(size_y) * (SZW+QRY_W)'(qy_abs);
    magx   = NUM_W'({px, {(FRAC_BITS-8){1'b0}}});
    magy   = NUM_W'({py, {(FRAC_BITS-8){1'b0}}});
  end

  // cells and their magnitudes
  logic signed [CELL_W-1:0] cellx, celly;
  logic [CELL_W-1:0]        cellx_abs, celly_abs;
  logic [SZW-1:0]           mod_x, mod_y;

  always_comb begin
    cellx     = CELL_W'(posx_r >>> FRAC_BITS);
    celly     = CELL_W'(posy_r >>> FRAC_BITS);
    cellx_abs = cellx[CELL_W-1] ? CELL_W'(-cellx) : CELL_W'(cellx);
    celly_abs = celly[CELL_W-1] ? CELL_W'(-celly) : CELL_W'(celly);
    mod_x     = size_x - 1'b1;
    mod_y     = size_y - 1'b1;
  end

  // shared dividers: scaling pass, then wrap pass
  logic             div_start;
  logic [NUM_W-1:0] dnum_x, dnum_y, quo_x, quo_y;
  logic [SRC_W-1:0] dden_x, dden_y, rem_x, rem_y;
  logic             done_x, done_y;

  always_comb begin
    div_start = (state_r == S_MUL) || (state_r == S_CELL);
    if (state_r == S_MUL) begin
      dnum_x = magx;
      dnum_y = magy;
      dden_x = den_x;
      dden_y = den_y;
    end else begin
      dnum_x = NUM_W'(cellx_abs);
      dnum_y = NUM_W'(celly_abs);
      dden_x = SRC_W'(mod_x);
      dden_y = SRC_W'(mod_y);
    end
  end

  bwms_div #(.NUM_W(NUM_W), .DEN_W(SRC_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum_x), .den(dden_x),
    .done(done_x), .quo(quo_x), .rem(rem_x)
  );

  bwms_div #(.NUM_W(NUM_W), .DEN_W(SRC_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum_y), .den(dden_y),
    .done(done_y), .quo(quo_y), .rem(rem_y)
  );

  // floor of the signed quotient
  logic signed [POS_W-1:0] posx_nxt, posy_nxt;

  always_comb begin
    posx_nxt = $signed({1'b0, quo_x});
    posy_nxt = $signed({1'b0, quo_y});
    if (qx_r[QRY_W-1])
      posx_nxt = (rem_x != '0) ? -posx_nxt - POS_W'(1) : -posx_nxt;
    if (qy_r[QRY_W-1])
      posy_nxt = (rem_y != '0) ? -posy_nxt - POS_W'(1) : -posy_nxt;
  end

  // non-negative wrapped cells
  logic [SZW-1:0] rx, ry, x0_nxt, y0_nxt, x1_nxt, y1_nxt;

  always_comb begin
    rx = SZW'(rem_x);
    ry = SZW'(rem_y);
    x0_nxt = (cellx[CELL_W-1] && rx != '0) ? mod_x - rx : rx;
    y0_nxt = (celly[CELL_W-1] && ry != '0) ? mod_y - ry : ry;
    x1_nxt = (x0_nxt + 1'b1 == mod_x) ? '0 : x0_nxt + 1'b1;
    y1_nxt = (y0_nxt + 1'b1 == mod_y) ? '0 : y0_nxt + 1'b1;
  end

  // table port
  entry_t           mem [2**IDX_W];
  entry_t           mem_rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic [ADD_W-1:0] rd_sum;
  logic             mem_we;

  always_comb begin
    case (rd_cnt_r)
      3'd0:    rd_sum = ADD_W'(rb0_r) + ADD_W'(x0_r);
      3'd1:    rd_sum = ADD_W'(rb0_r) + ADD_W'(x1_r);
      3'd2:    rd_sum = ADD_W'(rb1_r) + ADD_W'(x0_r);
      default: rd_sum = ADD_W'(rb1_r) + ADD_W'(x1_r);
    endcase
    rd_addr = IDX_W'(rd_sum);
    mem_we  = in_acc && (in_ch.req_type == REQ_WRITE);
  end

  always_ff @(posedge clk) begin
    if (mem_we)
      mem[in_ch.entry_index] <= '{u: in_ch.entry_u, v: in_ch.entry_v};
    mem_rdata_r <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load from the last blend, clear when taken
      if (state_r == S_BY && out_free)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_acc && in_ch.req_type == REQ_QUERY) state_r <= S_MUL;
        S_MUL:  state_r <= S_DIV;
        S_DIV:  if (done_x) state_r <= S_CELL;
        S_CELL: state_r <= S_MOD;
        S_MOD:  if (done_x) state_r <= S_WRAP;
        S_WRAP: state_r <= S_ADDR;
        S_ADDR: begin
          rd_cnt_r <= '0;
          state_r  <= S_READ;
        end
        S_READ: begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
          if (rd_cnt_r == 3'd4) state_r <= S_BT;
        end
        S_BT:   state_r <= S_BB;
        S_BB:   state_r <= S_BY;
        S_BY: begin
          if (out_free)
            state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx_r <= in_ch.query_x;
      qy_r <= in_ch.query_y;
    end
    if (state_r == S_DIV && done_x) begin
      posx_r <= posx_nxt;
      posy_r <= posy_nxt;
    end
    if (state_r == S_MOD && done_x) begin
      x0_r <= x0_nxt;
      x1_r <= x1_nxt;
      y0_r <= y0_nxt;
      y1_r <= y1_nxt;
    end
    if (state_r == S_ADDR) begin
      rb0_r <= ROW_W'(y0_r) * ROW_W'(size_x);
      rb1_r <= ROW_W'(y1_r) * ROW_W'(size_x);
    end
    if (state_r == S_READ && rd_cnt_r != 3'd0)
      ent_r[2'(rd_cnt_r - 1'b1)] <= mem_rdata_r;
    if (state_r == S_BT) begin
      top_r.u <= blend(ent_r[0].u, ent_r[1].u, posx_r[FRAC_BITS-1:0]);
      top_r.v <= blend(ent_r[0].v, ent_r[1].v, posx_r[FRAC_BITS-1:0]);
    end
    if (state_r == S_BB) begin
      bot_r.u <= blend(ent_r[2].u, ent_r[3].u, posx_r[FRAC_BITS-1:0]);
      bot_r.v <= blend(ent_r[2].v, ent_r[3].v, posx_r[FRAC_BITS-1:0]);
    end
    if (state_r == S_BY && out_free) begin
      out_u_r <= blend(top_r.u, bot_r.u, posy_r[FRAC_BITS-1:0]);
      out_v_r <= blend(top_r.v, bot_r.v, posy_r[FRAC_BITS-1:0]);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.sample_u = out_u_r;
  assign out_ch.sample_v = out_v_r;

`ifndef SYNTHESIS
  // a query leaves idle for the multiply step
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.req_type == REQ_QUERY |=> state_r == S_MUL)
    else $error("query item did not start the sequencer");

  // a table write stays in idle
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.req_type == REQ_WRITE |=> state_r == S_IDLE)
    else $error("write item left idle");

  // a sample appears only from the last blend step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_BY))
    else $error("sample raised outside the final blend");

  // both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    done_x == done_y)
    else $error("divider passes out of step");
`endif

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the wrap-around bilinear map sampler: loads the table
// in use, runs directed and random write/query items over several register
// settings, and checks each sample against a bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bwms_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 150;

  typedef struct {
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [COMP_W-1:0] entry_u;
    logic signed [COMP_W-1:0] entry_v;
    logic signed [QRY_W-1:0]  query_x;
    logic signed [QRY_W-1:0]  query_y;
  } request_t;

  typedef struct {
    logic signed [COMP_W-1:0] u;
    logic signed [COMP_W-1:0] v;
  } sample_t;

  // Bilinear sample predictor with its own copy of the table and registers
  class bilinear_predictor;
    logic [ENTRY_W-1:0] coord_table [int];
    logic [MAP_W-1:0]   map_w, map_h;
    logic [SRC_W-1:0]   src_w, src_h;
    sample_t            pending_samples[$];
    int                 errors;

    function new();
      map_w = MAP_W_RST;
      map_h = MAP_H_RST;
      src_w = SRC_W_RST;
      src_h = SRC_H_RST;
      errors = 0;
    endfunction

    function longint used_size(logic [MAP_W-1:0] s);
      if (s < 2) return 2;
      if (s > MAX_DIM_DEF) return MAX_DIM_DEF;
      return s;
    endfunction

    function void set_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] val);
      case (r)
        REG_MAP_WIDTH:     map_w = val[MAP_W-1:0];
        REG_MAP_HEIGHT:    map_h = val[MAP_W-1:0];
        REG_SOURCE_WIDTH:  src_w = val[SRC_W-1:0];
        REG_SOURCE_HEIGHT: src_h = val[SRC_W-1:0];
        default: ;
      endcase
    endfunction

    // scale one axis, floor into cell and fraction, wrap both cells
    function void axis(longint q, longint size, longint src,
                       output longint c0, output longint c1, output longint fr);
      longint den, num, pos, cell_idx, m;
      den = (src == 0) ? 1 : src;
      num = size * q * (longint'(1) << (FRAC_BITS_DEF - 8));
      pos = num / den;
      if ((num % den) != 0 && num < 0) pos = pos - 1;
      cell_idx = pos >>> FRAC_BITS_DEF;
      fr = pos & ((longint'(1) << FRAC_BITS_DEF) - 1);
      m = size - 1;
      c0 = cell_idx % m;
      if (c0 < 0) c0 = c0 + m;
      c1 = (cell_idx + 1) % m;
      if (c1 < 0) c1 = c1 + m;
    endfunction

    // true when wrapped index v of an axis can be hit by some query
    function bit reaches(longint v, longint size, longint src);
      longint den, scl, lo, hi, m;
      den = (src == 0) ? 1 : src;
      scl = longint'(1) << (FRAC_BITS_DEF - 8);
      lo = (size * (-(longint'(1) << (QRY_W - 1))) * scl) / den - 1;
      hi = (size * ((longint'(1) << (QRY_W - 1)) - 1) * scl) / den;
      lo = (lo >>> FRAC_BITS_DEF) - 1;
      hi = (hi >>> FRAC_BITS_DEF) + 2;
      m = size - 1;
      if (hi - lo + 1 >= m) return 1'b1;
      return (((v - lo) % m + m) % m) <= hi - lo;
    endfunction

    function longint lerp(longint a, longint b, longint f);
      longint one;
      one = longint'(1) << FRAC_BITS_DEF;
      return ((one - f) * a + f * b + (one >>> 1)) >>> FRAC_BITS_DEF;
    endfunction

    // one component of one entry; hi selects v
    function longint comp(longint row, longint col, longint w, bit hi);
      int                 idx;
      logic [ENTRY_W-1:0] e;
      idx = int'((row * w + col) & ((longint'(1) << IDX_W) - 1));
      e = coord_table.exists(idx) ? coord_table[idx] : '0;
      return hi ? longint'($signed(e[ENTRY_W-1:COMP_W])) : longint'($signed(e[COMP_W-1:0]));
    endfunction

    function void note_request(request_t rq);
      longint  w, h, x0, x1, fx, y0, y1, fy, top, bot;
      sample_t s;
      if (rq.req_type == REQ_WRITE) begin
        coord_table[int'(rq.entry_index)] = {rq.entry_v, rq.entry_u};
        return;
      end
      w = used_size(map_w);
      h = used_size(map_h);
      axis(longint'(rq.query_x), w, longint'(src_w), x0, x1, fx);
      axis(longint'(rq.query_y), h, longint'(src_h), y0, y1, fy);
      top = lerp(comp(y0, x0, w, 0), comp(y0, x1, w, 0), fx);
      bot = lerp(comp(y1, x0, w, 0), comp(y1, x1, w, 0), fx);
      s.u = COMP_W'(lerp(top, bot, fy));
      top = lerp(comp(y0, x0, w, 1), comp(y0, x1, w, 1), fx);
      bot = lerp(comp(y1, x0, w, 1), comp(y1, x1, w, 1), fx);
      s.v = COMP_W'(lerp(top, bot, fy));
      pending_samples.push_back(s);
    endfunction

    function void check_sample(logic signed [COMP_W-1:0] u, logic signed [COMP_W-1:0] v);
      sample_t s;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample item: sample_u %0d sample_v %0d", u, v);
        errors++;
        return;
      end
      s = pending_samples.pop_front();
      if (u !== s.u) begin
        $error("sample_u mismatch: expected %0d actual %0d", s.u, u);
        errors++;
      end
      if (v !== s.v) begin
        $error("sample_v mismatch: expected %0d actual %0d", s.v, v);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  bwms_in_if  req_ch ();
  bwms_out_if smp_ch ();

  bilinear_wrap_map_sampler_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (smp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bilinear_predictor predictor = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, check on each accepted item
  always @(posedge clk) begin
    if (rst_n && smp_ch.valid && smp_ch.ready)
      predictor.check_sample(smp_ch.sample_u, smp_ch.sample_v);
    smp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(r));
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    predictor.set_reg(r, val);
  endtask

  // valid stays high between back-to-back items
  task automatic send_request(request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rq.req_type;
    req_ch.entry_index <= rq.entry_index;
    req_ch.entry_u     <= rq.entry_u;
    req_ch.entry_v     <= rq.entry_v;
    req_ch.query_x     <= rq.query_x;
    req_ch.query_y     <= rq.query_y;
    do @(posedge clk); while (!req_ch.ready);
    predictor.note_request(rq);
  endtask

  task automatic store_entry(int idx, logic signed [COMP_W-1:0] u,
                             logic signed [COMP_W-1:0] v);
    request_t rq;
    rq.req_type    = REQ_WRITE;
    rq.entry_index = IDX_W'(idx);
    rq.entry_u     = u;
    rq.entry_v     = v;
    rq.query_x     = QRY_W'($urandom);
    rq.query_y     = QRY_W'($urandom);
    send_request(rq);
  endtask

  task automatic query_point(logic signed [QRY_W-1:0] x, logic signed [QRY_W-1:0] y);
    request_t rq;
    rq.req_type    = REQ_QUERY;
    rq.entry_index = IDX_W'($urandom);
    rq.entry_u     = $urandom;
    rq.entry_v     = $urandom;
    rq.query_x     = x;
    rq.query_y     = y;
    send_request(rq);
  endtask

  // quiesce so register writes land on an idle block
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (predictor.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // every entry that a wrapped cell pair can reach under the current registers
  task automatic fill_map();
    longint w, h;
    w = predictor.used_size(predictor.map_w);
    h = predictor.used_size(predictor.map_h);
    for (int r = 0; r < h - 1; r++)
      for (int c = 0; c < w - 1; c++)
        if (predictor.reaches(r, h, longint'(predictor.src_h)) &&
            predictor.reaches(c, w, longint'(predictor.src_w)))
          store_entry(int'((r * w + c) & ((1 << IDX_W) - 1)), $urandom, $urandom);
  endtask

  function automatic logic signed [QRY_W-1:0] rand_coord();
    logic signed [QRY_W-1:0] q;
    q = QRY_W'($urandom);
    return q >>> $urandom_range(0, 20);
  endfunction

  // register settings per phase: map w, map h, source w, source h
  int unsigned phase_cfg [6][4] = '{
    '{5, 4, 1, 1},
    '{0, 1, 0, 134217727},
    '{2047, 2, 134217727, 3},
    '{2, 1024, 0, 134217727},
    '{3, 1500, 300, 120000000},
    '{7, 9, 135168, 200}
  };

  initial begin
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type    = REQ_WRITE;
    req_ch.entry_index = '0;
    req_ch.entry_u     = '0;
    req_ch.entry_v     = '0;
    req_ch.query_x     = '0;
    req_ch.query_y     = '0;
    smp_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 38 : (p < 4) ? 56 : 0;
      recv_idle_pct = (p < 2) ? 56 : (p < 4) ? 38 : 0;
      if (p > 0) drain();
      write_reg(REG_MAP_WIDTH,     phase_cfg[p][0]);
      write_reg(REG_MAP_HEIGHT,    phase_cfg[p][1]);
      write_reg(REG_SOURCE_WIDTH,  phase_cfg[p][2]);
      write_reg(REG_SOURCE_HEIGHT, phase_cfg[p][3]);
      fill_map();

      if (p == 0) begin
        // directed: component extremes, writes far outside the map, query extremes
        store_entry(0, 32'sh7fffffff, 32'sh80000000);
        store_entry(1, 32'sh80000000, 32'sh7fffffff);
        store_entry(5, 32'sh40000000, -32'sh40000000);
        store_entry(6, -1, 1);
        store_entry(20'hFFFFF, 32'sh7fffffff, 32'sh80000000);
        store_entry(20'h55555, 32'sh12345678, 32'sh0);
        query_point(0, 0);
        query_point(28'sh7ffffff, 28'sh7ffffff);
        query_point(-28'sh8000000, -28'sh8000000);
        query_point(28'sh7ffffff, -28'sh8000000);
        query_point(-1, -1);
        query_point(1, 1);
        query_point(28'sh80, -28'sh80);
        query_point(28'sh33, 28'sh1cd);
        query_point(-28'sh101, 28'sh7f);
        store_entry(0, 32'sh0, 32'sh0);
        query_point(28'sh40, 28'sh40);
      end

      // random mix of writes and queries
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(99) < 35)
          store_entry($urandom_range(0, (1 << IDX_W) - 1), $urandom, $urandom);
        else if ($urandom_range(1))
          query_point(QRY_W'($urandom), QRY_W'($urandom));
        else
          query_point(rand_coord(), rand_coord());
      end
    end

    drain();
    if (predictor.errors == 0 && predictor.pending_samples.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
